### rtl/fcd_pkg.sv
// Shared types, register indexes and defaults for the frontier cell detector.
package fcd_pkg;

  localparam int MAX_ROWS_DEFAULT    = 1024;
  localparam int MAX_COLUMNS_DEFAULT = 1024;

  localparam int CODE_W  = 16;
  localparam int SIZE_W  = 11;
  localparam int COORD_W = 10;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_MAP_ROWS      = 3'd0;
  localparam logic [2:0] REG_MAP_COLUMNS   = 3'd1;
  localparam logic [2:0] REG_OBSERVED_FREE = 3'd2;
  localparam logic [2:0] REG_UNKNOWN       = 3'd3;
  localparam logic [2:0] REG_INFERRED_FREE = 3'd4;
  localparam logic [2:0] REG_INFERRED_WALL = 3'd5;
  localparam logic [2:0] REG_DOMINATED     = 3'd6;
  localparam logic [2:0] REG_INFLATED_WALL = 3'd7;

  typedef struct packed {
    logic signed [CODE_W-1:0] cell_code;
    logic                     first_of_map;
  } cell_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] frontier_column;
    logic [COORD_W-1:0] frontier_row;
  } frontier_out_t;

endpackage

### rtl/fcd_ram.sv
// Generic RAM with one write port and two registered read ports.
module fcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/frontier_cell_detector.sv
// Top level of the streaming four-neighbor frontier cell detector.
//
// Usage: grid cells enter on the in channel (valid/ready) in column-major
// order, all rows of a column top to bottom, then the next column. A cell
// transaction with first_of_map set restarts the row and column counters at
// the origin. Each accepted cell judges the cell to its left; when that cell
// holds the observed-free code and one of its four neighbors holds one of the
// five frontier-opening codes, one result transaction with its column and
// row leaves on the out channel. Border rows and columns never give results.
// Throughput is one cell per clock cycle while no result is blocked at the
// output. The accepted cell and its column buffer reads are registered in the
// stencil stage, and the stencil compare loads the output register. The two
// column buffers are RAMs with two registered read ports each; a write from the
// previous cell to an address being read is forwarded. Reset clears the counters
// and pipeline valids and loads the register defaults; the buffers are not
// cleared, and no clearing pass runs. When the receiver stalls, the output
// register holds its result and the input keeps flowing until a second result
// would need the output register. Registers are written through the APB port;
// the user must write them only while the block is idle; it is not enforced.
module frontier_cell_detector #(
  parameter int MAX_ROWS    = fcd_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = fcd_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fcd_pkg::cell_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fcd_pkg::frontier_out_t              out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fcd_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [fcd_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  import fcd_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLUMNS);
  // Widths for size compares: they hold the clamped size and the counter plus two.
  localparam int RCW   = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;
  localparam int CCW   = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
  // Widths used to mask coordinates down to the output field width.
  localparam int ROXW  = (ROW_W > COORD_W) ? ROW_W : COORD_W;
  localparam int COXW  = (COL_W > COORD_W) ? COL_W : COORD_W;

  // Configuration registers.
  logic [SIZE_W-1:0] map_rows;
  logic [SIZE_W-1:0] map_columns;
  logic [CODE_W-1:0] observed_free_code;
  logic [CODE_W-1:0] unknown_code;
  logic [CODE_W-1:0] inferred_free_code;
  logic [CODE_W-1:0] inferred_wall_code;
  logic [CODE_W-1:0] dominated_free_code;
  logic [CODE_W-1:0] inflated_wall_code;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows            <= SIZE_W'(1024);
      map_columns         <= SIZE_W'(1024);
      observed_free_code  <= CODE_W'(1);
      unknown_code        <= CODE_W'(0);
      inferred_free_code  <= CODE_W'(2);
      inferred_wall_code  <= CODE_W'(3);
      dominated_free_code <= CODE_W'(4);
      inflated_wall_code  <= CODE_W'(5);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAP_ROWS:      map_rows            <= pwdata[SIZE_W-1:0];
        REG_MAP_COLUMNS:   map_columns         <= pwdata[SIZE_W-1:0];
        REG_OBSERVED_FREE: observed_free_code  <= pwdata[CODE_W-1:0];
        REG_UNKNOWN:       unknown_code        <= pwdata[CODE_W-1:0];
        REG_INFERRED_FREE: inferred_free_code  <= pwdata[CODE_W-1:0];
        REG_INFERRED_WALL: inferred_wall_code  <= pwdata[CODE_W-1:0];
        REG_DOMINATED:     dominated_free_code <= pwdata[CODE_W-1:0];
        REG_INFLATED_WALL: inflated_wall_code  <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_MAP_ROWS:      prdata = CFG_DATA_W'(map_rows);
      REG_MAP_COLUMNS:   prdata = CFG_DATA_W'(map_columns);
      REG_OBSERVED_FREE: prdata = CFG_DATA_W'(observed_free_code);
      REG_UNKNOWN:       prdata = CFG_DATA_W'(unknown_code);
      REG_INFERRED_FREE: prdata = CFG_DATA_W'(inferred_free_code);
      REG_INFERRED_WALL: prdata = CFG_DATA_W'(inferred_wall_code);
      REG_DOMINATED:     prdata = CFG_DATA_W'(dominated_free_code);
      REG_INFLATED_WALL: prdata = CFG_DATA_W'(inflated_wall_code);
      default:           prdata = '0;
    endcase
  end

  // Sizes clamped to the range the buffers and counters support.
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;

  always_comb begin
    if (map_rows == '0) begin
      rows_eff = RCW'(1);
    end else if (RCW'(map_rows) > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(map_rows);
    end
    if (map_columns == '0) begin
      cols_eff = CCW'(1);
    end else if (CCW'(map_columns) > CCW'(MAX_COLUMNS)) begin
      cols_eff = CCW'(MAX_COLUMNS);
    end else begin
      cols_eff = CCW'(map_columns);
    end
  end

  function automatic logic opens_frontier(input logic [CODE_W-1:0] code);
    return code == unknown_code || code == inferred_free_code ||
           code == inferred_wall_code || code == dominated_free_code ||
           code == inflated_wall_code;
  endfunction

  // Scan position of the next cell.
  logic [ROW_W-1:0] row_position;
  logic [COL_W-1:0] column_position;
  logic [ROW_W-1:0] row_position_next;
  logic [COL_W-1:0] column_position_next;

  logic             in_accept;
  logic [ROW_W-1:0] acc_row;
  logic [COL_W-1:0] acc_col;
  logic [ROW_W-1:0] acc_row_up;
  logic [ROW_W-1:0] acc_row_down;

  assign in_accept    = in_valid & in_ready;
  assign acc_row      = in_data.first_of_map ? '0 : row_position;
  assign acc_col      = in_data.first_of_map ? '0 : column_position;
  assign acc_row_up   = ROW_W'(acc_row - 1'b1);
  assign acc_row_down = ROW_W'(acc_row + 1'b1);

  always_comb begin
    if (RCW'(acc_row) + RCW'(1) >= rows_eff) begin
      row_position_next = '0;
      if (CCW'(acc_col) + CCW'(1) >= cols_eff) begin
        column_position_next = '0;
      end else begin
        column_position_next = COL_W'(acc_col + 1'b1);
      end
    end else begin
      row_position_next    = acc_row_down;
      column_position_next = acc_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      column_position <= '0;
    end else if (in_accept) begin
      row_position    <= row_position_next;
      column_position <= column_position_next;
    end
  end

  // Stencil stage: holds the accepted cell while the buffer reads land.
  logic              s1_valid;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic [CODE_W-1:0] s1_cell;
  // Forwarding of the previous cell's buffer writes to this cell's reads.
  logic              fwd_centre;
  logic              fwd_down;
  logic              fwd_left;
  logic              fwd_up;
  logic [CODE_W-1:0] fwd_cell;
  logic [CODE_W-1:0] fwd_shift;

  logic [CODE_W-1:0] newer_rd_centre;
  logic [CODE_W-1:0] newer_rd_down;
  logic [CODE_W-1:0] older_rd_left;
  logic [CODE_W-1:0] older_rd_up;

  logic [CODE_W-1:0] centre;
  logic [CODE_W-1:0] down;
  logic [CODE_W-1:0] left;
  logic [CODE_W-1:0] up;
  logic              interior;
  logic              hit;
  logic              s1_go;
  logic              s1_fire;

  assign centre = fwd_centre ? fwd_cell  : newer_rd_centre;
  assign down   = fwd_down   ? fwd_cell  : newer_rd_down;
  assign left   = fwd_left   ? fwd_shift : older_rd_left;
  assign up     = fwd_up     ? fwd_shift : older_rd_up;

  assign interior = (s1_col >= COL_W'(2)) && (CCW'(s1_col) < cols_eff) &&
                    (s1_row >= ROW_W'(1)) && (RCW'(s1_row) + RCW'(2) <= rows_eff);

  assign hit = s1_valid && interior && (centre == observed_free_code) &&
               (opens_frontier(down) || opens_frontier(up) ||
                opens_frontier(s1_cell) || opens_frontier(left));

  // The stage waits only when it has a result and a stalled, full output.
  assign s1_go    = !hit || !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_go;
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_row     <= acc_row;
      s1_col     <= acc_col;
      s1_cell    <= in_data.cell_code;
      fwd_cell   <= s1_cell;
      fwd_shift  <= centre;
      fwd_centre <= s1_fire && (acc_row == s1_row);
      fwd_down   <= s1_fire && (acc_row_down == s1_row);
      fwd_left   <= s1_fire && (acc_row == s1_row);
      fwd_up     <= s1_fire && (acc_row_up == s1_row);
    end
  end

  // Column buffers: the newer column shifts into the older one row by row.
  fcd_ram #(
    .WIDTH(CODE_W),
    .DEPTH(MAX_ROWS)
  ) newer_column_store (
    .clk    (clk),
    .we     (s1_fire),
    .waddr  (s1_row),
    .wdata  (s1_cell),
    .re     (in_accept),
    .raddr_a(acc_row),
    .raddr_b(acc_row_down),
    .rdata_a(newer_rd_centre),
    .rdata_b(newer_rd_down)
  );

  fcd_ram #(
    .WIDTH(CODE_W),
    .DEPTH(MAX_ROWS)
  ) older_column_store (
    .clk    (clk),
    .we     (s1_fire),
    .waddr  (s1_row),
    .wdata  (centre),
    .re     (in_accept),
    .raddr_a(acc_row),
    .raddr_b(acc_row_up),
    .rdata_a(older_rd_left),
    .rdata_b(older_rd_up)
  );

  // Output register.
  logic [COXW-1:0] judged_col;
  logic [ROXW-1:0] judged_row;

  assign judged_col = COXW'(s1_col - 1'b1);
  assign judged_row = ROXW'(s1_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && hit) begin
      out_data.frontier_column <= judged_col[COORD_W-1:0];
      out_data.frontier_row    <= judged_row[COORD_W-1:0];
    end
  end

  // A stalled stencil stage keeps its cell and row.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_row) && $stable(s1_cell))
    else $error("stencil stage lost its cell while stalled");

  // Input backpressure only comes from a blocked result.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && hit && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // An accepted cell always lands in the stencil stage.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted cell missing from stencil stage");

endmodule

### sim/fcd_checker.sv
// Scoreboard for the frontier cell detector: predicts frontier transactions and checks them.
`timescale 1ns / 1ps
module fcd_checker #(
  parameter int MAX_ROWS    = fcd_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = fcd_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  fcd_pkg::cell_in_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  fcd_pkg::frontier_out_t          out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [fcd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]  pwdata,
  output int                              fail_count,
  output int                              pending,
  output int                              compared
);

  logic [fcd_pkg::SIZE_W-1:0] rows_cfg;
  logic [fcd_pkg::SIZE_W-1:0] cols_cfg;
  logic [fcd_pkg::CODE_W-1:0] free_cfg;
  logic [fcd_pkg::CODE_W-1:0] unknown_cfg;
  logic [fcd_pkg::CODE_W-1:0] inf_free_cfg;
  logic [fcd_pkg::CODE_W-1:0] inf_wall_cfg;
  logic [fcd_pkg::CODE_W-1:0] dom_free_cfg;
  logic [fcd_pkg::CODE_W-1:0] infl_wall_cfg;

  // Two most recent columns of the grid, indexed by row.
  logic [fcd_pkg::CODE_W-1:0] older_cells [MAX_ROWS];
  logic [fcd_pkg::CODE_W-1:0] newer_cells [MAX_ROWS];
  int unsigned row_at;
  int unsigned col_at;

  fcd_pkg::frontier_out_t expected_frontiers [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    compared   = 0;
  end

  function automatic int unsigned clamp_size(input logic [fcd_pkg::SIZE_W-1:0] v,
                                             input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic bit opens_frontier(input logic [fcd_pkg::CODE_W-1:0] code);
    return code == unknown_cfg || code == inf_free_cfg || code == inf_wall_cfg ||
           code == dom_free_cfg || code == infl_wall_cfg;
  endfunction

  // Each accepted cell judges the cell one column to its left on the same row.
  task automatic predict_frontier(input fcd_pkg::cell_in_t item);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    logic [fcd_pkg::CODE_W-1:0] code;
    fcd_pkg::frontier_out_t hit;
    code = item.cell_code;
    rows = clamp_size(rows_cfg, MAX_ROWS);
    cols = clamp_size(cols_cfg, MAX_COLUMNS);
    if (item.first_of_map) begin
      row_at = 0;
      col_at = 0;
    end
    r = row_at;
    c = col_at;
    if (c >= 2 && c < cols && r >= 1 && r + 2 <= rows && r < MAX_ROWS) begin
      // The row above has already been shifted, so its left column sits in older_cells.
      if (newer_cells[r] == free_cfg &&
          (opens_frontier(newer_cells[r + 1]) || opens_frontier(older_cells[r - 1]) ||
           opens_frontier(code) || opens_frontier(older_cells[r]))) begin
        hit.frontier_column = fcd_pkg::COORD_W'(c - 1);
        hit.frontier_row    = fcd_pkg::COORD_W'(r);
        expected_frontiers = {expected_frontiers, hit};
      end
    end
    if (r < MAX_ROWS) begin
      older_cells[r] = newer_cells[r];
      newer_cells[r] = code;
    end
    if (r + 1 >= rows) begin
      row_at = 0;
      col_at = (c + 1 >= cols) ? 0 : c + 1;
    end else begin
      row_at = r + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_cfg      = 11'd1024;
      cols_cfg      = 11'd1024;
      free_cfg      = 16'd1;
      unknown_cfg   = 16'd0;
      inf_free_cfg  = 16'd2;
      inf_wall_cfg  = 16'd3;
      dom_free_cfg  = 16'd4;
      infl_wall_cfg = 16'd5;
      row_at = 0;
      col_at = 0;
      expected_frontiers.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          fcd_pkg::REG_MAP_ROWS:      rows_cfg      = pwdata[fcd_pkg::SIZE_W-1:0];
          fcd_pkg::REG_MAP_COLUMNS:   cols_cfg      = pwdata[fcd_pkg::SIZE_W-1:0];
          fcd_pkg::REG_OBSERVED_FREE: free_cfg      = pwdata[fcd_pkg::CODE_W-1:0];
          fcd_pkg::REG_UNKNOWN:       unknown_cfg   = pwdata[fcd_pkg::CODE_W-1:0];
          fcd_pkg::REG_INFERRED_FREE: inf_free_cfg  = pwdata[fcd_pkg::CODE_W-1:0];
          fcd_pkg::REG_INFERRED_WALL: inf_wall_cfg  = pwdata[fcd_pkg::CODE_W-1:0];
          fcd_pkg::REG_DOMINATED:     dom_free_cfg  = pwdata[fcd_pkg::CODE_W-1:0];
          fcd_pkg::REG_INFLATED_WALL: infl_wall_cfg = pwdata[fcd_pkg::CODE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_frontiers.size() == 0) begin
          $error("Frontier transaction with nothing expected: column %0d row %0d",
                 out_data.frontier_column, out_data.frontier_row);
          fail_count++;
        end else begin
          fcd_pkg::frontier_out_t want;
          want = expected_frontiers.pop_front();
          if (out_data.frontier_column !== want.frontier_column) begin
            $error("frontier_column: expected %0d, actual %0d",
                   want.frontier_column, out_data.frontier_column);
            fail_count++;
          end
          if (out_data.frontier_row !== want.frontier_row) begin
            $error("frontier_row: expected %0d, actual %0d",
                   want.frontier_row, out_data.frontier_row);
            fail_count++;
          end
          compared++;
        end
      end
      if (in_valid && in_ready) predict_frontier(in_data);
    end
    pending = expected_frontiers.size();
  end

endmodule

### sim/tb.sv
// Testbench top: streams grids and register writes into the frontier cell detector.
`timescale 1ns / 1ps
module tb;
  import fcd_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int RANDOM_CELLS  = 1250;
  // Settling after the last expected result is taken covers cells that give no result.
  localparam int SETTLE_CYCLES = 6;
  localparam logic [CODE_W-1:0] FILLER = 16'h1234;

  typedef enum {FREE_FLOW, SENDER_GAPS, RECEIVER_STALLS, BOTH_IDLE} idle_mode_t;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  cell_in_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  frontier_out_t         out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int compared;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int idle_pct    = 0;
  int stall_pct   = 0;
  int cells_sent  = 0;
  int setups      = 0;
  int cycle_count = 0;
  // Cells in one full grid under the current size registers, after clamping.
  int grid_cells  = 1;

  // Shadow of every register, so stimulus can pick cells that match the codes.
  logic [CFG_DATA_W-1:0] reg_val [REG_MAP_ROWS:REG_INFLATED_WALL];

  frontier_cell_detector uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // The checker watches both channels and the register port on its own.
  fcd_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether it takes a result.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      FREE_FLOW:       begin idle_pct = 0;  stall_pct = 0;  end
      SENDER_GAPS:     begin idle_pct = 49; stall_pct = 0;  end
      RECEIVER_STALLS: begin idle_pct = 0;  stall_pct = 49; end
      default:         begin idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // Writes all eight registers from the shadow. Each write is a setup phase, an
  // access phase and a quiet phase, so that psel never drops and rises in one step.
  task automatic write_all();
    for (int i = REG_MAP_ROWS; i <= REG_INFLATED_WALL; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {i[2:0], 2'b00};
      pwdata  <= reg_val[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
    end
    setups++;
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(7));
      1:       return 16'h8000 + 16'($urandom_range(3));
      2:       return 16'h7ffc + 16'($urandom_range(3));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(19))
      0:       return 11'd0;
      1:       return 11'd2047;
      2:       return 11'd1024;
      3:       return 11'd1;
      4:       return 11'd2;
      default: return 11'($urandom_range(12, 3));
    endcase
  endfunction

  // Mostly free cells and frontier-opening codes, so frontiers are common.
  function automatic logic [CODE_W-1:0] random_cell();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    if (pick < 80) return reg_val[$urandom_range(REG_INFLATED_WALL, REG_UNKNOWN)][CODE_W-1:0];
    return 16'($urandom());
  endfunction

  // New sizes and random codes; the upper data bits of code writes carry junk.
  task automatic new_setup(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
    int rows_eff;
    int cols_eff;
    reg_val[REG_MAP_ROWS]    = {21'd0, rows};
    reg_val[REG_MAP_COLUMNS] = {21'd0, cols};
    for (int i = REG_OBSERVED_FREE; i <= REG_INFLATED_WALL; i++) begin
      reg_val[i] = {16'($urandom()), pick_code()};
    end
    rows_eff = (rows == 0) ? 1 : ((rows > MAX_ROWS_DEFAULT) ? MAX_ROWS_DEFAULT : rows);
    cols_eff = (cols == 0) ? 1 : ((cols > MAX_COLUMNS_DEFAULT) ? MAX_COLUMNS_DEFAULT : cols);
    grid_cells = rows_eff * cols_eff;
    write_all();
  endtask

  // One cell transaction. Valid is only lowered when the sender idles, and it is
  // raised again at a later edge.
  task automatic send_cell(input logic [CODE_W-1:0] code, input logic first);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{cell_code: code, first_of_map: first};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cells_sent++;
  endtask

  // Streams cells in scan order. Only noisy streams set the restart flag at later
  // grid boundaries, dropping it now and then, and restart in the middle of a grid.
  task automatic run_cells(input int count, input bit noisy, input bit lead_first);
    logic first;
    for (int i = 0; i < count; i++) begin
      if (i == 0) first = lead_first;
      else if (i % grid_cells == 0) first = noisy && ($urandom_range(9) != 0);
      else first = noisy && ($urandom_range(99) == 0);
      send_cell(random_cell(), first);
    end
  endtask

  // Waits until every predicted frontier has been taken, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CODE_W-1:0] grid [5][5];
    int goal;
    int phase;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed 5x5 grid. Most codes sit at the ends of the 16-bit range, and the
    // interior cells exercise every opening code, every neighbor direction, a free
    // cell with no opening neighbor, and free cells on the border.
    set_idling(FREE_FLOW);
    reg_val[REG_MAP_ROWS]      = 32'd5;
    reg_val[REG_MAP_COLUMNS]   = 32'd5;
    reg_val[REG_OBSERVED_FREE] = 32'h0000_8000;
    reg_val[REG_UNKNOWN]       = 32'h0000_7fff;
    reg_val[REG_INFERRED_FREE] = 32'h0000_ffff;
    reg_val[REG_INFERRED_WALL] = 32'h0000_0000;
    reg_val[REG_DOMINATED]     = 32'h0000_0001;
    reg_val[REG_INFLATED_WALL] = 32'h0000_5a5a;
    write_all();
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) grid[r][c] = FILLER;
    end
    grid[0][2] = reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    grid[0][3] = reg_val[REG_UNKNOWN][CODE_W-1:0];
    grid[1][0] = reg_val[REG_INFERRED_FREE][CODE_W-1:0];
    grid[1][1] = reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    grid[1][3] = reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    grid[1][4] = reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    grid[2][1] = reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    grid[2][2] = reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    grid[2][3] = reg_val[REG_INFERRED_WALL][CODE_W-1:0];
    grid[3][1] = reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    grid[3][3] = reg_val[REG_OBSERVED_FREE][CODE_W-1:0];
    grid[3][4] = reg_val[REG_INFLATED_WALL][CODE_W-1:0];
    grid[4][1] = reg_val[REG_DOMINATED][CODE_W-1:0];
    for (int c = 0; c < 5; c++) begin
      for (int r = 0; r < 5; r++) send_cell(grid[r][c], (r == 0 && c == 0));
    end
    drain();

    // One full grid at the tallest size, with an oversized row count that must be
    // clamped. It also fills both column buffers at every row, so later streams
    // can never read an entry that was never written.
    set_idling(RECEIVER_STALLS);
    new_setup(11'd2047, 11'd3);
    run_cells(grid_cells, 1'b0, 1'b1);
    drain();

    // Single-row grid at the clamped widest size: no frontiers, and the scan
    // wraps past the last column without a restart flag.
    set_idling(SENDER_GAPS);
    new_setup(11'd0, 11'd2047);
    run_cells(grid_cells + 6, 1'b0, 1'b1);
    drain();

    // Shrink the grid in the middle of a scan: the row counter lies beyond the new
    // row count, so that cell is skipped and the counter wraps.
    set_idling(BOTH_IDLE);
    new_setup(11'd8, 11'd8);
    run_cells(20, 1'b0, 1'b1);
    drain();
    new_setup(11'd3, 11'd12);
    run_cells(40, 1'b1, 1'b0);
    drain();

    // Random setups, cycling through the idling modes.
    goal  = cells_sent + RANDOM_CELLS;
    phase = 0;
    while (cells_sent < goal) begin
      set_idling(idle_mode_t'(phase % 4));
      new_setup(pick_size(), pick_size());
      run_cells($urandom_range(140, 60), 1'b1, $urandom_range(3) != 0);
      drain();
      phase++;
    end

    $display("Streamed %0d cell transactions through %0d register setups, grid sizes",
             cells_sent, setups);
    $display("from degenerate to the clamped maximum; %0d frontier transactions compared.",
             compared);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
